/* sv/md5_stream_hasher_assert.svh */
// ---------------------------------------------------------------------------
// md5_stream_hasher assertion macros
// Concurrent check wrappers; they reduce to nothing in synthesis builds.
// ---------------------------------------------------------------------------
`ifndef MD5_STREAM_HASHER_ASSERT_SVH
`define MD5_STREAM_HASHER_ASSERT_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define MD5SH_ASSERT_PROP(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("md5_stream_hasher: check failed");

// condition must never be true outside reset
`define MD5SH_ASSERT_NEVER(name, clk, rst_n, cond) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("md5_stream_hasher: forbidden condition seen");

`else

`define MD5SH_ASSERT_PROP(name, clk, rst_n, prop)
`define MD5SH_ASSERT_NEVER(name, clk, rst_n, cond)

`endif

`endif

/* sv/md5sh_pkg.sv */
// ---------------------------------------------------------------------------
// md5sh_pkg
// Types, codes and constant tables shared by the MD5 stream hasher.
// ---------------------------------------------------------------------------
package md5sh_pkg;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       byte_present;
        logic       is_last;
    } t_in_item;

    typedef struct packed {
        logic [63:0] digest_part;
        logic        last_part;
    } t_out_item;

    // operation kinds passed from the front end to the back end
    localparam logic [1:0] OP_BYTE      = 2'd0;
    localparam logic [1:0] OP_BYTE_LAST = 2'd1;
    localparam logic [1:0] OP_FINISH    = 2'd2;

    typedef struct packed {
        logic       valid;
        logic [1:0] kind;
        logic [7:0] byte_val;
    } t_op;

    typedef logic [3:0][31:0] t_chain;

    localparam t_chain C_IV = {32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301};

    localparam logic [7:0] C_PAD_BYTE = 8'h80;
    localparam logic [5:0] C_LEN_POS  = 6'd56;
    localparam logic [5:0] C_LAST_POS = 6'd63;

    localparam logic [0:63][31:0] C_STEP_K = {
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};

    // rotate amounts, indexed by {round, step[1:0]}
    localparam logic [0:15][4:0] C_ROT = {
        5'd7, 5'd12, 5'd17, 5'd22,
        5'd5, 5'd9,  5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23,
        5'd6, 5'd10, 5'd15, 5'd21};

    function automatic logic [31:0] f_rotl(input logic [31:0] v, input logic [4:0] n);
        logic [63:0] dbl;
        dbl = {v, v} << n;
        return dbl[63:32];
    endfunction

endpackage

/* sv/md5sh_front.sv */
// ---------------------------------------------------------------------------
// md5sh_front
// Accepts input items, sorts them into byte / byte-and-end / end operations,
// drops empty items and queues the rest for the back end.
// ---------------------------------------------------------------------------
module md5sh_front #(
    parameter int DEPTH = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  md5sh_pkg::t_in_item i_in_item,
    output md5sh_pkg::t_op      o_op,
    input  logic                i_op_pop
);
    import md5sh_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_op              r_q [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    logic s_store;
    logic s_take;
    t_op  s_new;

    assign full = (r_cnt == FULL_CNT);

    always_comb begin
        s_new          = '0;
        s_new.valid    = 1'b1;
        s_new.byte_val = i_in_item.byte_value;
        if (i_in_item.byte_present && i_in_item.is_last) begin
            s_new.kind = OP_BYTE_LAST;
        end else if (i_in_item.byte_present) begin
            s_new.kind = OP_BYTE;
        end else begin
            s_new.kind = OP_FINISH;
        end
    end

    // an item with neither byte nor end mark is taken and dropped
    assign s_store = push && !full && (i_in_item.byte_present || i_in_item.is_last);
    assign s_take  = i_op_pop && (r_cnt != '0);

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (s_store) begin
            n_wr = (r_wr == LAST_PTR) ? '0 : r_wr + 1'b1;
        end
        if (s_take) begin
            n_rd = (r_rd == LAST_PTR) ? '0 : r_rd + 1'b1;
        end
        if (s_store && !s_take) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!s_store && s_take) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_store) begin
            r_q[r_wr] <= s_new;
        end
    end

    always_comb begin
        o_op       = r_q[r_rd];
        o_op.valid = (r_cnt != '0);
    end

endmodule

/* sv/md5sh_round.sv */
// ---------------------------------------------------------------------------
// md5sh_round
// MD5 compression datapath: one of the 64 steps per cycle on the working
// words, fetching one message word per step from the block buffer.
// ---------------------------------------------------------------------------
module md5sh_round (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  md5sh_pkg::t_chain i_chain,
    output logic [3:0]        o_widx,
    input  logic [31:0]       i_word,
    output logic              o_done,
    output md5sh_pkg::t_chain o_abcd
);
    import md5sh_pkg::*;

    logic        r_run, n_run;
    logic        r_done, n_done;
    logic [5:0]  r_step, n_step;
    logic [31:0] r_a, r_b, r_c, r_d;

    logic [3:0]  s_j;
    logic [31:0] s_f;
    logic [31:0] s_sum;
    logic [31:0] s_t;

    assign s_j = r_step[3:0];

    always_comb begin
        case (r_step[5:4])
            2'd0: begin
                s_f    = (r_b & r_c) | (~r_b & r_d);
                o_widx = s_j;
            end
            2'd1: begin
                s_f    = (r_b & r_d) | (r_c & ~r_d);
                o_widx = (s_j << 2) + s_j + 4'd1;
            end
            2'd2: begin
                s_f    = r_b ^ r_c ^ r_d;
                o_widx = (s_j << 1) + s_j + 4'd5;
            end
            default: begin
                s_f    = r_c ^ (r_b | ~r_d);
                o_widx = (s_j << 3) - s_j;
            end
        endcase
    end

    assign s_sum = r_a + s_f + i_word + C_STEP_K[r_step];
    assign s_t   = f_rotl(s_sum, C_ROT[{r_step[5:4], r_step[1:0]}]) + r_b;

    always_comb begin
        n_run  = r_run;
        n_step = r_step;
        n_done = 1'b0;
        if (i_start) begin
            n_run  = 1'b1;
            n_step = '0;
        end else if (r_run) begin
            n_step = r_step + 1'b1;
            if (r_step == C_LAST_POS) begin
                n_run  = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_run  <= n_run;
            r_done <= n_done;
            r_step <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_chain[0];
            r_b <= i_chain[1];
            r_c <= i_chain[2];
            r_d <= i_chain[3];
        end else if (r_run) begin
            r_a <= r_d;
            r_d <= r_c;
            r_c <= r_b;
            r_b <= s_t;
        end
    end

    assign o_done = r_done;
    assign o_abcd = {r_d, r_c, r_b, r_a};

endmodule

/* sv/md5sh_back.sv */
// ---------------------------------------------------------------------------
// md5sh_back
// Carries out queued operations: packs bytes into the block buffer, counts
// message bits, pads, drives the compression datapath and queues the two
// digest halves.
// ---------------------------------------------------------------------------
module md5sh_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  md5sh_pkg::t_op       i_op,
    output logic                 o_op_pop,
    output logic                 o_res_empty,
    input  logic                 i_res_pop,
    output md5sh_pkg::t_out_item o_res
);
    import md5sh_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_COMP = 3'd1;
    localparam logic [2:0] ST_PAD  = 3'd2;
    localparam logic [2:0] ST_LEN  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0]  r_st, n_st;
    logic [2:0]  r_ret, n_ret;
    logic [63:0] r_cnt, n_cnt;
    t_chain      r_chain, n_chain;
    logic [3:0][7:0] r_buf [16];

    t_out_item   r_oq [2];
    logic        r_oq_rd, n_oq_rd;
    logic [1:0]  r_oq_cnt, n_oq_cnt;

    logic [5:0]  s_pos;
    logic        s_start;
    logic        s_wr_byte;
    logic        s_wr_pad;
    logic        s_wr_len;
    logic        s_wr_clear;
    logic        s_load_out;
    logic [3:0]  s_widx;
    logic        s_done;
    t_chain      s_abcd;

    assign s_pos = r_cnt[8:3];

    md5sh_round u_round (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (s_start),
        .i_chain (r_chain),
        .o_widx  (s_widx),
        .i_word  (r_buf[s_widx]),
        .o_done  (s_done),
        .o_abcd  (s_abcd)
    );

    always_comb begin
        n_st       = r_st;
        n_ret      = r_ret;
        n_cnt      = r_cnt;
        n_chain    = r_chain;
        o_op_pop   = 1'b0;
        s_start    = 1'b0;
        s_wr_byte  = 1'b0;
        s_wr_pad   = 1'b0;
        s_wr_len   = 1'b0;
        s_wr_clear = 1'b0;
        s_load_out = 1'b0;
        case (r_st)
            ST_IDLE: begin
                if (i_op.valid) begin
                    o_op_pop = 1'b1;
                    case (i_op.kind)
                        OP_BYTE, OP_BYTE_LAST: begin
                            s_wr_byte = 1'b1;
                            n_cnt     = r_cnt + 64'd8;
                            if (s_pos == C_LAST_POS) begin
                                // block complete: compress before anything else
                                s_start = 1'b1;
                                n_st    = ST_COMP;
                                n_ret   = (i_op.kind == OP_BYTE_LAST) ? ST_PAD : ST_IDLE;
                            end else if (i_op.kind == OP_BYTE_LAST) begin
                                n_st = ST_PAD;
                            end
                        end
                        OP_FINISH: begin
                            n_st = ST_PAD;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_PAD: begin
                s_wr_pad = 1'b1;
                s_start  = 1'b1;
                n_st     = ST_COMP;
                if (s_pos >= C_LEN_POS) begin
                    // no room for the length: it goes in an extra block
                    n_ret = ST_LEN;
                end else begin
                    s_wr_len = 1'b1;
                    n_ret    = ST_OUT;
                end
            end
            ST_LEN: begin
                s_wr_clear = 1'b1;
                s_wr_len   = 1'b1;
                s_start    = 1'b1;
                n_st       = ST_COMP;
                n_ret      = ST_OUT;
            end
            ST_COMP: begin
                if (s_done) begin
                    for (int k = 0; k < 4; k++) begin
                        n_chain[k] = r_chain[k] + s_abcd[k];
                    end
                    n_st = r_ret;
                end
            end
            ST_OUT: begin
                // hold until both halves of the previous digest are gone
                if (r_oq_cnt == 2'd0) begin
                    s_load_out = 1'b1;
                    n_chain    = C_IV;
                    n_cnt      = '0;
                    n_st       = ST_IDLE;
                end
            end
            default: begin
                n_st = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_oq_rd  = r_oq_rd;
        n_oq_cnt = r_oq_cnt;
        if (s_load_out) begin
            n_oq_rd  = 1'b0;
            n_oq_cnt = 2'd2;
        end else if (i_res_pop && (r_oq_cnt != 2'd0)) begin
            n_oq_rd  = ~r_oq_rd;
            n_oq_cnt = r_oq_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= ST_IDLE;
            r_ret    <= ST_IDLE;
            r_cnt    <= '0;
            r_chain  <= C_IV;
            r_oq_rd  <= 1'b0;
            r_oq_cnt <= 2'd0;
        end else begin
            r_st     <= n_st;
            r_ret    <= n_ret;
            r_cnt    <= n_cnt;
            r_chain  <= n_chain;
            r_oq_rd  <= n_oq_rd;
            r_oq_cnt <= n_oq_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int w = 0; w < 16; w++) begin
            for (int l = 0; l < 4; l++) begin
                if (s_wr_len && (w >= 14)) begin
                    // length words take priority over the zero fill
                    r_buf[w][l] <= r_cnt[(w & 1) * 32 + l * 8 +: 8];
                end else if (s_wr_clear) begin
                    r_buf[w][l] <= 8'h00;
                end else if (s_wr_pad && (6'(w * 4 + l) == s_pos)) begin
                    r_buf[w][l] <= C_PAD_BYTE;
                end else if (s_wr_pad && (6'(w * 4 + l) > s_pos)) begin
                    r_buf[w][l] <= 8'h00;
                end else if (s_wr_byte && (6'(w * 4 + l) == s_pos)) begin
                    r_buf[w][l] <= i_op.byte_val;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_load_out) begin
            r_oq[0].digest_part <= {r_chain[1], r_chain[0]};
            r_oq[0].last_part   <= 1'b0;
            r_oq[1].digest_part <= {r_chain[3], r_chain[2]};
            r_oq[1].last_part   <= 1'b1;
        end
    end

    assign o_res_empty = (r_oq_cnt == 2'd0);
    assign o_res       = r_oq[r_oq_rd];

endmodule

/* sv/md5_stream_hasher.sv */
// ---------------------------------------------------------------------------
// md5_stream_hasher: takes one byte item per cycle while the back end is idle;
// the 64th byte of a block starts a compression that holds further items, and
// each padding block is compressed before the digest halves are queued.
// Reset: synchronous, active low; empties queues, loads IV, clears bit count.
// ---------------------------------------------------------------------------
`include "md5_stream_hasher_assert.svh"

module md5_stream_hasher #(
    parameter int OP_QUEUE_DEPTH = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    output logic                 full,
    input  md5sh_pkg::t_in_item  i_in_item,
    output logic                 empty,
    input  logic                 pop,
    output md5sh_pkg::t_out_item o_out_item
);
    import md5sh_pkg::*;

    t_op  s_op;
    logic s_op_pop;
    logic s_pop_lo;
    logic s_pop_hi;
    logic s_hi_ready;

    md5sh_front #(
        .DEPTH (OP_QUEUE_DEPTH)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .push      (push),
        .full      (full),
        .i_in_item (i_in_item),
        .o_op      (s_op),
        .i_op_pop  (s_op_pop)
    );

    md5sh_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (s_op),
        .o_op_pop    (s_op_pop),
        .o_res_empty (empty),
        .i_res_pop   (pop),
        .o_res       (o_out_item)
    );

    assign s_pop_lo   = pop && !empty && !o_out_item.last_part;
    assign s_pop_hi   = pop && !empty && o_out_item.last_part;
    assign s_hi_ready = !empty && o_out_item.last_part;

    `MD5SH_ASSERT_NEVER(a_op_pop_when_empty, i_clk, i_rst_n, s_op_pop && !s_op.valid)
    `MD5SH_ASSERT_PROP(a_second_half_follows, i_clk, i_rst_n, s_pop_lo |=> s_hi_ready)
    `MD5SH_ASSERT_PROP(a_drained_after_final, i_clk, i_rst_n, s_pop_hi |=> empty)

endmodule

/* dv/tb.sv */
// ---------------------------------------------------------------------------
// tb: md5_stream_hasher testbench
// Streams byte items into the hasher and checks every digest half against a
// local MD5 predictor. Directed messages cover the empty message, single
// bytes at the extremes, a last item with and without a byte, and ignored
// items; random messages follow, sized around the padding boundaries, with
// random gaps and stalls on both queue sides.
// ---------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import md5sh_pkg::*;

    localparam int WATCHDOG_CYCLES = 4000;
    localparam int DRAIN_CYCLES    = 200;
    localparam int TARGET_ITEMS    = 1900;

    localparam logic [7:0] PAD_BYTE  = 8'h80;
    localparam int         LEN_SLOT  = 56;
    localparam int         BLOCK_END = 63;

    localparam logic [0:3][31:0] INIT_CHAIN = {
        32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476};

    localparam logic [0:63][31:0] STEP_ADD = {
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};

    localparam logic [0:15][4:0] SHIFT_BY = {
        5'd7, 5'd12, 5'd17, 5'd22,
        5'd5, 5'd9,  5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23,
        5'd6, 5'd10, 5'd15, 5'd21};

    class digest_scoreboard;
        logic [31:0] chain [4];
        logic [31:0] words [16];
        logic [63:0] bit_total;
        t_out_item   digest_q [$];
        int          errors;

        function new();
            restart();
            foreach (words[w]) words[w] = '0;
            errors = 0;
        endfunction

        function void restart();
            for (int w = 0; w < 4; w++) chain[w] = INIT_CHAIN[w];
            bit_total = '0;
        endfunction

        function logic [31:0] rol(input logic [31:0] v, input logic [4:0] n);
            return (v << n) | (v >> (6'd32 - n));
        endfunction

        function void put_byte(input int pos, input logic [7:0] v);
            words[pos >> 2][(pos % 4) * 8 +: 8] = v;
        endfunction

        function void mix_block();
            logic [31:0] a, b, c, d, f, t;
            int          rnd, j, widx;
            a = chain[0];
            b = chain[1];
            c = chain[2];
            d = chain[3];
            for (int i = 0; i < 64; i++) begin
                rnd = i / 16;
                j   = i % 16;
                case (rnd)
                    0: begin
                        f = (b & c) | (~b & d);
                        widx = j;
                    end
                    1: begin
                        f = (b & d) | (c & ~d);
                        widx = (5 * j + 1) % 16;
                    end
                    2: begin
                        f = b ^ c ^ d;
                        widx = (3 * j + 5) % 16;
                    end
                    default: begin
                        f = c ^ (b | ~d);
                        widx = (7 * j) % 16;
                    end
                endcase
                t = a + f + words[widx] + STEP_ADD[i];
                t = rol(t, SHIFT_BY[rnd * 4 + j % 4]) + b;
                a = d;
                d = c;
                c = b;
                b = t;
            end
            chain[0] += a;
            chain[1] += b;
            chain[2] += c;
            chain[3] += d;
        endfunction

        function void note_item(input t_in_item it);
            int        pos;
            t_out_item lo_half;
            t_out_item hi_half;
            if (it.byte_present) begin
                pos = int'(bit_total[8:3]);
                put_byte(pos, it.byte_value);
                bit_total += 64'd8;
                if (pos == BLOCK_END) mix_block();
            end
            if (!it.is_last) return;
            pos = int'(bit_total[8:3]);
            put_byte(pos, PAD_BYTE);
            for (int p = pos + 1; p <= BLOCK_END; p++) put_byte(p, 8'h00);
            // no room for the length: flush this block and start a clean one
            if (pos >= LEN_SLOT) begin
                mix_block();
                foreach (words[w]) words[w] = '0;
            end
            words[14] = bit_total[31:0];
            words[15] = bit_total[63:32];
            mix_block();
            lo_half  = t_out_item'{digest_part: {chain[1], chain[0]}, last_part: 1'b0};
            hi_half  = t_out_item'{digest_part: {chain[3], chain[2]}, last_part: 1'b1};
            digest_q = {digest_q, lo_half, hi_half};
            restart();
        endfunction

        function void check_result(input t_out_item got);
            t_out_item want;
            if (digest_q.size() == 0) begin
                $display("%0t: unexpected digest half %h last %b",
                         $time, got.digest_part, got.last_part);
                errors++;
                return;
            end
            want = digest_q.pop_front();
            if (got.digest_part !== want.digest_part) begin
                $display("%0t: digest_part expected %h actual %h",
                         $time, want.digest_part, got.digest_part);
                errors++;
            end
            if (got.last_part !== want.last_part) begin
                $display("%0t: last_part expected %b actual %b",
                         $time, want.last_part, got.last_part);
                errors++;
            end
        endfunction

        function int pending();
            return digest_q.size();
        endfunction
    endclass

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      push;
    logic      full;
    t_in_item  i_in_item;
    logic      empty;
    logic      pop;
    t_out_item o_out_item;

    digest_scoreboard sb = new();
    bit tx_burst;
    bit rx_burst;
    int items_sent;

    md5_stream_hasher i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_in_item  (i_in_item),
        .empty      (empty),
        .pop        (pop),
        .o_out_item (o_out_item)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (push && !full) sb.note_item(i_in_item);
            if (pop && !empty) sb.check_result(o_out_item);
        end
    end

    // mostly short gaps, now and then a long one; none at all in a burst
    function automatic int idle_len(input bit burst);
        int r;
        if (burst) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic t_in_item make_item(input logic [7:0] v, input logic present,
                                           input logic last);
        return t_in_item'{byte_value: v, byte_present: present, is_last: last};
    endfunction

    task automatic send_item(input t_in_item it);
        int gap;
        gap = idle_len(tx_burst);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_item <= it;
        push      <= 1'b1;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        if (it.byte_present || it.is_last) items_sent++;
    endtask

    task automatic send_message(input int len);
        bit tail_byte;
        tx_burst  = ($urandom_range(0, 3) == 0);
        tail_byte = (len > 0) && ($urandom_range(0, 1) == 1);
        for (int k = 0; k < len; k++) begin
            // drop in an ignored item now and then
            if ($urandom_range(0, 19) == 0)
                send_item(make_item(8'($urandom_range(0, 255)), 1'b0, 1'b0));
            send_item(make_item(8'($urandom_range(0, 255)), 1'b1,
                                tail_byte && (k == len - 1)));
        end
        if (!tail_byte)
            send_item(make_item(8'($urandom_range(0, 255)), 1'b0, 1'b1));
    endtask

    function automatic int pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35) return $urandom_range(0, 16);
        if (r < 75) return $urandom_range(17, 130);
        // land the pad byte just either side of the length slot or block end
        case ($urandom_range(0, 3))
            0: return 64 * $urandom_range(0, 2) + 55;
            1: return 64 * $urandom_range(0, 2) + 56;
            2: return 64 * $urandom_range(0, 2) + 63;
            default: return 64 * $urandom_range(1, 2);
        endcase
    endfunction

    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < WATCHDOG_CYCLES) begin
            @(posedge i_clk);
            if ((push && !full) || (pop && !empty)) idle = 0;
            else idle++;
        end
        $display("md5_stream_hasher: mismatch");
        $finish;
    end

    initial begin : result_sink
        int stall;
        pop      <= 1'b0;
        rx_burst = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if ($urandom_range(0, 15) == 0) rx_burst = !rx_burst;
            stall = idle_len(rx_burst);
            if (stall > 0) begin
                pop <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            pop <= 1'b1;
            @(posedge i_clk);
            while (empty) @(posedge i_clk);
        end
    end

    initial begin : stimulus
        int fixed_len [10];
        fixed_len  = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};
        i_rst_n    <= 1'b0;
        push       <= 1'b0;
        i_in_item  <= '0;
        tx_burst   = 1'b0;
        items_sent = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // ignored item, then the empty message
        send_item(make_item(8'hff, 1'b0, 1'b0));
        send_item(make_item(8'ha5, 1'b0, 1'b1));
        // single-byte messages with the byte on the last item
        send_item(make_item(8'h00, 1'b1, 1'b1));
        send_item(make_item(8'hff, 1'b1, 1'b1));
        // "abc"
        send_item(make_item(8'h61, 1'b1, 1'b0));
        send_item(make_item(8'h62, 1'b1, 1'b0));
        send_item(make_item(8'h63, 1'b1, 1'b1));
        // one byte, then a bare last item
        send_item(make_item(8'h5a, 1'b1, 1'b0));
        send_item(make_item(8'h00, 1'b0, 1'b0));
        send_item(make_item(8'h3c, 1'b0, 1'b1));

        foreach (fixed_len[m]) send_message(fixed_len[m]);
        while (items_sent < TARGET_ITEMS) send_message(pick_length());
        push <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("md5_stream_hasher: match");
        end else begin
            $display("md5_stream_hasher: mismatch");
        end
        $finish;
    end
endmodule
